// ===== sv/cel_pkg.sv =====
// ----------------------------------------------------------------------------
// cel_pkg
// Shared types and constants for the circular event log.
// ----------------------------------------------------------------------------
package cel_pkg;

  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_READ   = 3'd1;
  localparam logic [2:0] CMD_DIR    = 3'd2;
  localparam logic [2:0] CMD_LIMIT  = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam int FQ_DEPTH = 2;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_APPEND = 3'd1,
    OP_READ   = 3'd2,
    OP_DIR    = 3'd3,
    OP_LIMIT  = 3'd4,
    OP_CLEAR  = 3'd5
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    logic signed [31:0] stamp;
    logic [7:0]         evt;
    logic               backward;
    logic [7:0]         limit;
  } op_t;

  typedef struct packed {
    logic               has_record;
    logic signed [31:0] stamp;
    logic [7:0]         evt;
    logic [7:0]         count;
  } res_t;

endpackage

// ===== sv/cel_front.sv =====
// ----------------------------------------------------------------------------
// cel_front
// Input queue: accepts items, decodes the command and holds them for the back.
// ----------------------------------------------------------------------------
module cel_front
  import cel_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         in_cmd,
  input  logic signed [31:0] in_stamp_in,
  input  logic [7:0]         in_event_in,
  input  logic               in_backward_in,
  input  logic [7:0]         in_limit_in,
  output logic               op_valid,
  output op_t                op,
  input  logic               op_take
);

  localparam int FAW = $clog2(FQ_DEPTH);

  op_t              q_r [FQ_DEPTH];
  logic [FAW-1:0]   wptr_r, rptr_r;
  logic [FAW:0]     cnt_r;
  op_kind_t         kind;
  logic             do_push;

  always_comb begin
    case (in_cmd)
      CMD_APPEND: kind = OP_APPEND;
      CMD_READ:   kind = OP_READ;
      CMD_DIR:    kind = OP_DIR;
      CMD_LIMIT:  kind = OP_LIMIT;
      CMD_CLEAR:  kind = OP_CLEAR;
      default:    kind = OP_NONE;
    endcase
  end

  assign full     = (cnt_r == (FAW+1)'(FQ_DEPTH));
  assign do_push  = push && !full;
  assign op_valid = (cnt_r != '0);
  assign op       = q_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wptr_r] <= '{kind: kind, stamp: in_stamp_in, evt: in_event_in,
                       backward: in_backward_in, limit: in_limit_in};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (op_take) rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_r + (FAW+1)'(do_push) - (FAW+1)'(op_take);
    end
  end

endmodule

// ===== sv/cel_back.sv =====
// ----------------------------------------------------------------------------
// cel_back
// Executor: slot pointers, record memory and the result stage.
// ----------------------------------------------------------------------------
module cel_back
  import cel_pkg::*;
#(
  parameter int SLOTS = 256
)(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           op_valid,
  input  op_t            op,
  output logic           op_take,
  input  logic [OQ_AW:0] oq_level,
  output logic           res_valid,
  output res_t           res
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = ((AW > 8) ? AW : 8) + 1;
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
  localparam logic [AW-1:0] LAST    = AW'(SLOTS - 1);

  logic [39:0]   mem [SLOTS];
  logic [39:0]   rdata_r;
  logic [AW-1:0] old_r, app_r, cur_r;
  logic [AW-1:0] old_nxt, app_nxt, cur_nxt;
  logic          bwd_r, bwd_nxt;
  logic          resp_v_r, resp_has_r;
  logic [7:0]    resp_cnt_r;
  logic          has_nxt;
  logic          wr_en, rd_en;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] cnt_cur, cnt_new, lim_w, sum_w, dif_w;
  logic [7:0]    cnt_sat;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    return (s == LAST) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
    return (s == '0) ? LAST : s - 1'b1;
  endfunction

  function automatic logic [CW-1:0] held(input logic [AW-1:0] a, input logic [AW-1:0] o);
    logic [CW-1:0] ae, oe;
    ae = CW'(a);
    oe = CW'(o);
    return (ae >= oe) ? ae - oe : ae + SLOTS_C - oe;
  endfunction

  assign op_take = op_valid && ((4'(oq_level) + 4'(resp_v_r)) < 4'(OQ_DEPTH));

  assign cnt_cur = held(app_r, old_r);
  assign lim_w   = CW'(op.limit);
  assign sum_w   = (CW'(old_r) + lim_w >= SLOTS_C) ? CW'(old_r) + lim_w - SLOTS_C
                                                   : CW'(old_r) + lim_w;
  assign dif_w   = (CW'(app_r) >= lim_w) ? CW'(app_r) - lim_w
                                         : CW'(app_r) + SLOTS_C - lim_w;

  always_comb begin
    old_nxt = old_r;
    app_nxt = app_r;
    cur_nxt = cur_r;
    bwd_nxt = bwd_r;
    has_nxt = 1'b0;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = cur_r;
    if (op_take) begin
      case (op.kind)
        OP_APPEND: begin
          wr_en   = 1'b1;
          app_nxt = slot_inc(app_r);
          if (app_nxt == old_r) begin
            old_nxt = slot_inc(old_r);
            cur_nxt = bwd_r ? app_nxt : old_nxt;
          end
        end
        OP_READ: begin
          if (bwd_r) begin
            if (cur_r == old_r) begin
              cur_nxt = app_r;
            end else begin
              cur_nxt = slot_dec(cur_r);
              rd_addr = cur_nxt;
              rd_en   = 1'b1;
              has_nxt = 1'b1;
            end
          end else begin
            if (cur_r == app_r) begin
              cur_nxt = old_r;
            end else begin
              rd_en   = 1'b1;
              has_nxt = 1'b1;
              cur_nxt = slot_inc(cur_r);
            end
          end
        end
        OP_DIR: begin
          bwd_nxt = op.backward;
          cur_nxt = op.backward ? app_r : old_r;
        end
        OP_LIMIT: begin
          if (op.limit != 8'd0 && cnt_cur > lim_w) begin
            cur_nxt = bwd_r ? sum_w[AW-1:0] : dif_w[AW-1:0];
          end
        end
        OP_CLEAR: begin
          old_nxt = '0;
          app_nxt = '0;
          cur_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign cnt_new = held(app_nxt, old_nxt);
  assign cnt_sat = (cnt_new > CW'(255)) ? 8'hFF : cnt_new[7:0];

  // slots outside the held range are never read, so markers and clears
  // need no memory writes
  always_ff @(posedge clk) begin
    if (wr_en) mem[app_r] <= {op.stamp, op.evt};
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (op_take) begin
      resp_has_r <= has_nxt;
      resp_cnt_r <= cnt_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_r    <= '0;
      app_r    <= '0;
      cur_r    <= '0;
      bwd_r    <= 1'b0;
      resp_v_r <= 1'b0;
    end else begin
      old_r    <= old_nxt;
      app_r    <= app_nxt;
      cur_r    <= cur_nxt;
      bwd_r    <= bwd_nxt;
      resp_v_r <= op_take;
    end
  end

  assign res_valid      = resp_v_r;
  assign res.has_record = resp_has_r;
  assign res.stamp      = resp_has_r ? $signed(rdata_r[39:8]) : 32'sd0;
  assign res.evt        = resp_has_r ? rdata_r[7:0] : 8'd0;
  assign res.count      = resp_cnt_r;

endmodule

// ===== sv/cel_outq.sv =====
// ----------------------------------------------------------------------------
// cel_outq
// Result queue between the executor and the result ports.
// ----------------------------------------------------------------------------
module cel_outq
  import cel_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_valid,
  input  res_t           res,
  output logic [OQ_AW:0] level,
  output logic           empty,
  input  logic           pop,
  output res_t           head
);

  res_t             q_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wptr_r, rptr_r;
  logic [OQ_AW:0]   cnt_r;
  logic             do_pop;

  assign empty  = (cnt_r == '0);
  assign do_pop = pop && !empty;
  assign level  = cnt_r;
  assign head   = q_r[rptr_r];

  always_ff @(posedge clk) begin
    if (res_valid) q_r[wptr_r] <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (res_valid) wptr_r <= wptr_r + 1'b1;
      if (do_pop)    rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_r + (OQ_AW+1)'(res_valid) - (OQ_AW+1)'(do_pop);
    end
  end

endmodule

// ===== sv/circular_event_log_top.sv =====
// ----------------------------------------------------------------------------
// circular_event_log_top
// Ring log of timestamped event records with read cursor and overwrite.
// ----------------------------------------------------------------------------
// channel   handshake            payload
// input     push / full          in_cmd, in_stamp_in, in_event_in,
//                                in_backward_in, in_limit_in
// result    empty / pop          out_has_record, out_stamp_out, out_event_out,
//                                out_count
//
// One item per cycle sustained while results are popped; the executor
// takes one command per cycle. A result passes the input queue, then
// execute with the registered memory read, then the result queue, before
// it reaches the ports. Reset is synchronous; no clearing pass is needed.
// A full result queue stalls the executor; the input queue then fills.
// ----------------------------------------------------------------------------
module circular_event_log_top
  import cel_pkg::*;
#(
  parameter int SLOTS = 256
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         in_cmd,
  input  logic signed [31:0] in_stamp_in,
  input  logic [7:0]         in_event_in,
  input  logic               in_backward_in,
  input  logic [7:0]         in_limit_in,
  output logic               empty,
  input  logic               pop,
  output logic               out_has_record,
  output logic signed [31:0] out_stamp_out,
  output logic [7:0]         out_event_out,
  output logic [7:0]         out_count
);

  logic           op_valid, op_take, res_valid;
  op_t            op;
  res_t           res, head;
  logic [OQ_AW:0] oq_level;

  cel_front u_front (
    .clk, .rst_n, .push, .full,
    .in_cmd, .in_stamp_in, .in_event_in, .in_backward_in, .in_limit_in,
    .op_valid, .op, .op_take
  );

  cel_back #(.SLOTS(SLOTS)) u_back (
    .clk, .rst_n, .op_valid, .op, .op_take, .oq_level, .res_valid, .res
  );

  cel_outq u_outq (
    .clk, .rst_n, .res_valid, .res, .level(oq_level), .empty, .pop, .head
  );

  assign out_has_record = head.has_record;
  assign out_stamp_out  = head.stamp;
  assign out_event_out  = head.evt;
  assign out_count      = head.count;

endmodule

// ===== sv/cel_checker.sv =====
// ----------------------------------------------------------------------------
// cel_checker
// Port-level checks for the circular event log.
// ----------------------------------------------------------------------------
module cel_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic               out_has_record,
  input logic signed [31:0] out_stamp_out,
  input logic [7:0]         out_event_out,
  input logic [7:0]         out_count
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("results pending after reset");

  a_rst_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input queue full after reset");

  a_no_rec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_has_record) |-> (out_stamp_out == 32'sd0 && out_event_out == 8'd0))
    else $error("record fields nonzero without a record");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_stamp_out) && $stable(out_count)))
    else $error("stalled item changed");

endmodule

bind circular_event_log_top cel_checker u_chk (
  .clk(clk), .rst_n(rst_n), .full(full), .empty(empty), .pop(pop),
  .out_has_record(out_has_record), .out_stamp_out(out_stamp_out),
  .out_event_out(out_event_out), .out_count(out_count)
);
